>>> src/qcb_pkg.sv
// ----------------------------------------------------------------------------
// qcb_pkg
// Shared constants and types of the quadratic character bits unit.
// ----------------------------------------------------------------------------
package qcb_pkg;

	localparam int MAX_PRIMES = 32;
	localparam int IDX_W      = $clog2(MAX_PRIMES);
	localparam int CNT_W      = 6;
	localparam int Q_W        = 32;
	localparam int LIMB_W     = 64;
	localparam int NB_W       = 7;

	// input word fields: entry, prime, n_residue, limb
	localparam int TD_IN_W    = 136;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_FOLD,
		S_FOLDW,
		S_MUL,
		S_SQ,
		S_SQW,
		S_NR,
		S_NRW,
		S_JAC,
		S_JACW,
		S_NEXT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              go;
		logic [Q_W-1:0]    init;
		logic [LIMB_W-1:0] dividend;
		logic [NB_W-1:0]   nbits;
		logic [Q_W-1:0]    q;
	} mod_req_t;

	typedef struct packed {
		logic           done;
		logic           busy;
		logic [Q_W-1:0] rem;
	} mod_rsp_t;

	typedef struct packed {
		logic           go;
		logic [Q_W-1:0] a;
		logic [Q_W-1:0] n;
	} jac_req_t;

	typedef struct packed {
		logic done;
		logic minus;
	} jac_rsp_t;

endpackage

>>> src/qcb_ram.sv
// ----------------------------------------------------------------------------
// qcb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module qcb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/qcb_mod.sv
// ----------------------------------------------------------------------------
// qcb_mod
// Bit-serial remainder unit: shifts dividend bits into a running remainder.
// ----------------------------------------------------------------------------
module qcb_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  qcb_pkg::mod_req_t req,
	output qcb_pkg::mod_rsp_t rsp
);
	import qcb_pkg::*;

	logic [Q_W-1:0]    rem_q;
	logic [Q_W-1:0]    q_q;
	logic [LIMB_W-1:0] div_q;
	logic [NB_W-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [Q_W:0]      t;
	logic [Q_W:0]      td;

	always_comb begin
		t  = {rem_q, div_q[LIMB_W-1]};
		td = (t >= {1'b0, q_q}) ? (t - {1'b0, q_q}) : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - NB_W'(1);
				if (cnt_q == NB_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.init;
			div_q <= req.dividend;
			q_q   <= req.q;
		end else if (busy_q) begin
			rem_q <= td[Q_W-1:0];
			div_q <= {div_q[LIMB_W-2:0], 1'b0};
		end
	end

	assign rsp = '{done: done_q, busy: busy_q, rem: rem_q};

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q) else $error("remainder unit started while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q) else $error("done without a run");
	a_nbits: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> req.nbits != '0) else $error("empty remainder run");

endmodule

>>> src/qcb_jacobi.sv
// ----------------------------------------------------------------------------
// qcb_jacobi
// Binary Jacobi symbol unit, one shift, swap or subtract per cycle.
// ----------------------------------------------------------------------------
module qcb_jacobi (
	input  logic              clk,
	input  logic              arst_n,
	input  qcb_pkg::jac_req_t req,
	output qcb_pkg::jac_rsp_t rsp
);
	import qcb_pkg::*;

	logic [Q_W-1:0] a_q;
	logic [Q_W-1:0] n_q;
	logic           neg_q;
	logic           busy_q;
	logic           done_q;
	logic           minus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			minus_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
			end else if (busy_q && a_q == '0) begin
				busy_q  <= 1'b0;
				done_q  <= 1'b1;
				minus_q <= neg_q && (n_q == Q_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q   <= req.a;
			n_q   <= req.n;
			neg_q <= 1'b0;
		end else if (busy_q && a_q != '0) begin
			if (!a_q[0]) begin
				// factor of two: sign flips when n is 3 or 5 mod 8
				a_q <= a_q >> 1;
				if (n_q[2:0] == 3'd3 || n_q[2:0] == 3'd5) begin
					neg_q <= !neg_q;
				end
			end else if (a_q < n_q) begin
				// reciprocity
				a_q <= n_q;
				n_q <= a_q;
				if (a_q[1:0] == 2'd3 && n_q[1:0] == 2'd3) begin
					neg_q <= !neg_q;
				end
			end else begin
				a_q <= a_q - n_q;
			end
		end
	end

	assign rsp = '{done: done_q, minus: minus_q};

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q) else $error("jacobi unit started while busy");
	a_n_odd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> n_q[0]) else $error("jacobi modulus went even");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a run");

endmodule

>>> src/quadratic_character_bits_unit.sv
// Quadratic character bits unit. Words with tuser = 0 load one slot of the
// prime table (prime and N mod prime). Words with tuser = 1 carry a 64-bit
// limb of the square-root value, most significant first; each limb walks all
// 32 slots in turn through the table RAMs and folds the limb into that
// slot's running remainder with a bit-serial remainder unit. On a limb with
// tlast set, each counted slot with an odd prime of at least 3 further
// squares the remainder, reduces the square and N, and runs the binary
// Jacobi unit. One result word, bit j set when the symbol for slot j is -1,
// follows the closing limb; remainders then read as zero again. The running
// remainders live in a RAM guarded by one valid bit per slot, so no clearing
// pass is needed after reset. prime_count is written on cfg_we.
// ----------------------------------------------------------------------------
// quadratic_character_bits_unit
// Top level: sequencer, table RAMs, remainder and Jacobi units.
// ----------------------------------------------------------------------------
module quadratic_character_bits_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [qcb_pkg::CNT_W-1:0]  cfg_wdata,     // prime_count
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [qcb_pkg::TD_IN_W-1:0] s_tdata,      // entry, prime, n_residue, limb
	input  logic                       s_tuser,       // mode
	input  logic                       s_tlast,       // last
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [qcb_pkg::Q_W-1:0]    m_tdata        // character vector
);
	import qcb_pkg::*;

	// input word unpacking
	logic [IDX_W-1:0]  in_entry;
	logic [Q_W-1:0]    in_prime;
	logic [Q_W-1:0]    in_nres;
	logic [LIMB_W-1:0] in_limb;

	assign in_entry = s_tdata[4:0];
	assign in_prime = s_tdata[36:5];
	assign in_nres  = s_tdata[68:37];
	assign in_limb  = s_tdata[132:69];

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  pc_q;
	logic [IDX_W-1:0]  j_q;
	logic [LIMB_W-1:0] limb_q;
	logic              last_q;
	logic [MAX_PRIMES-1:0] rvalid_q;
	logic [Q_W-1:0]    q_q, nres_q, s_q, ss_q;
	logic [2*Q_W-1:0]  prod_q;
	logic [Q_W-1:0]    bits_q;
	logic              ovalid_q;
	logic [Q_W-1:0]    odata_q;

	logic              in_acc;
	logic              tab_we;
	logic [2*Q_W-1:0]  tab_rdata;
	logic              rem_we;
	logic [Q_W-1:0]    rem_rdata;
	logic [Q_W-1:0]    rem_cur;
	logic [Q_W-1:0]    fold_s;
	logic [CNT_W-1:0]  used;
	logic              counted;
	logic              jac_ok;
	logic [Q_W:0]      qsum;
	logic [Q_W-1:0]    qq;

	mod_req_t mreq;
	mod_rsp_t mrsp;
	jac_req_t jreq;
	jac_rsp_t jrsp;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign tab_we   = in_acc && !s_tuser;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	// prime and residue share one RAM word: {n_residue, prime}
	qcb_ram #(.WIDTH(2*Q_W), .DEPTH(MAX_PRIMES)) u_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (in_entry),
		.wdata ({in_nres, in_prime}),
		.raddr (j_q),
		.rdata (tab_rdata)
	);

	qcb_ram #(.WIDTH(Q_W), .DEPTH(MAX_PRIMES)) u_rem (
		.clk   (clk),
		.we    (rem_we),
		.waddr (j_q),
		.wdata (fold_s),
		.raddr (j_q),
		.rdata (rem_rdata)
	);

	qcb_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	qcb_jacobi u_jac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (jreq),
		.rsp    (jrsp)
	);

	// slot with no valid bit reads as a cleared remainder
	assign rem_cur = rvalid_q[j_q] ? rem_rdata : '0;
	// zero prime keeps its remainder at zero
	assign fold_s  = (q_q == '0) ? '0 : mrsp.rem;
	assign used    = (pc_q > CNT_W'(MAX_PRIMES)) ? CNT_W'(MAX_PRIMES) : pc_q;
	assign counted = ({1'b0, j_q} < used);
	assign jac_ok  = counted && q_q[0] && (q_q >= Q_W'(3));

	// Q = s^2 - N mod q, both operands already below q
	always_comb begin
		qsum = {1'b0, ss_q} + {1'b0, q_q} - {1'b0, mrsp.rem};
		qq   = (ss_q >= mrsp.rem) ? (ss_q - mrsp.rem) : qsum[Q_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		rem_we  = 1'b0;
		mreq    = '{go: 1'b0, init: '0, dividend: '0, nbits: '0, q: q_q};
		jreq    = '{go: 1'b0, a: qq, n: q_q};
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && s_tuser) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_FOLD;
			end
			S_FOLD: begin
				mreq    = '{go: 1'b1, init: rem_cur, dividend: limb_q,
					nbits: NB_W'(LIMB_W), q: tab_rdata[Q_W-1:0]};
				state_d = S_FOLDW;
			end
			S_FOLDW: begin
				if (mrsp.done) begin
					if (!last_q) begin
						rem_we  = 1'b1;
						state_d = S_NEXT;
					end else if (jac_ok) begin
						state_d = S_MUL;
					end else begin
						state_d = S_NEXT;
					end
				end
			end
			S_MUL: begin
				state_d = S_SQ;
			end
			S_SQ: begin
				mreq    = '{go: 1'b1, init: '0, dividend: prod_q,
					nbits: NB_W'(LIMB_W), q: q_q};
				state_d = S_SQW;
			end
			S_SQW: begin
				if (mrsp.done) begin
					state_d = S_NR;
				end
			end
			S_NR: begin
				mreq    = '{go: 1'b1, init: '0, dividend: {nres_q, {Q_W{1'b0}}},
					nbits: NB_W'(Q_W), q: q_q};
				state_d = S_NRW;
			end
			S_NRW: begin
				if (mrsp.done) begin
					state_d = S_JAC;
				end
			end
			S_JAC: begin
				jreq.go = 1'b1;
				state_d = S_JACW;
			end
			S_JACW: begin
				if (jrsp.done) begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				if (j_q == IDX_W'(MAX_PRIMES - 1)) begin
					state_d = last_q ? S_DONE : S_IDLE;
				end else begin
					state_d = S_RD;
				end
			end
			S_DONE: begin
				if (!ovalid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pc_q     <= '0;
			j_q      <= '0;
			rvalid_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
			if (tab_we) begin
				rvalid_q[in_entry] <= 1'b0;
			end
			if (rem_we) begin
				rvalid_q[j_q] <= 1'b1;
			end
			if (state_q == S_NEXT) begin
				j_q <= j_q + IDX_W'(1);
			end
			if (state_q == S_DONE && (!ovalid_q || m_tready)) begin
				ovalid_q <= 1'b1;
				rvalid_q <= '0;
			end else if (m_tvalid && m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser) begin
			limb_q <= in_limb;
			last_q <= s_tlast;
			bits_q <= '0;
		end
		if (state_q == S_FOLD) begin
			q_q    <= tab_rdata[Q_W-1:0];
			nres_q <= tab_rdata[2*Q_W-1:Q_W];
		end
		if (state_q == S_FOLDW && mrsp.done) begin
			s_q <= fold_s;
		end
		if (state_q == S_MUL) begin
			prod_q <= s_q * s_q;
		end
		if (state_q == S_SQW && mrsp.done) begin
			ss_q <= mrsp.rem;
		end
		if (state_q == S_JACW && jrsp.done) begin
			bits_q[j_q] <= jrsp.minus;
		end
		if (state_q == S_DONE && (!ovalid_q || m_tready)) begin
			odata_q <= bits_q;
		end
	end

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		tab_we |=> !rvalid_q[$past(in_entry)])
		else $error("load left a stale remainder");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result without a closing limb");
	a_idle_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (j_q == '0))
		else $error("slot counter not back at zero");

endmodule
